>>> rtl/hss_pkg.sv
// ----------------------------------------------------------------------------
// hss_pkg
// Types and constants shared by the hit stream store and its checker.
// ----------------------------------------------------------------------------
package hss_pkg;

   localparam int PASSAGE_W = 15;
   localparam int WORD_W    = 15;
   localparam int ENTRY_W   = 16;
   localparam int TOTAL_W   = 13;
   localparam int OP_W      = 3;

   // request operation codes
   typedef enum logic [OP_W-1:0] {
      OP_WRITE        = 3'd0,
      OP_READ_NEXT    = 3'd1,
      OP_READ_PASSAGE = 3'd2,
      OP_REWIND       = 3'd3,
      OP_CLEAR        = 3'd4
   } op_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRITE_WORD,
      ST_READ_FIRST,
      ST_READ_WORD,
      ST_SCAN
   } state_type;

   typedef struct packed {
      logic [OP_W-1:0]      op;
      logic [PASSAGE_W-1:0] passage;
      logic [WORD_W-1:0]    word;
   } req_type;

   typedef struct packed {
      logic [PASSAGE_W-1:0] hit_passage;
      logic [WORD_W-1:0]    hit_word;
      logic                 found;
      logic                 rejected;
      logic [TOTAL_W-1:0]   total_hits;
   } rsp_type;

   // memory port command
   typedef struct packed {
      logic               wr_en;
      logic               rd_en;
      logic [ENTRY_W-1:0] wr_data;
   } ram_cmd_type;

   // zero or sign bit set marks a passage marker
   function automatic logic is_marker(input logic [ENTRY_W-1:0] value);
      return (value == '0) || value[ENTRY_W-1];
   endfunction

   // stored marker form of a passage: its 16-bit negation
   function automatic logic [ENTRY_W-1:0] marker_of(input logic [PASSAGE_W-1:0] passage);
      return ENTRY_W'(0) - {1'b0, passage};
   endfunction

   // passage number recovered from a marker
   function automatic logic [PASSAGE_W-1:0] passage_of(input logic [ENTRY_W-1:0] marker);
      logic [ENTRY_W-1:0] neg;
      neg = ENTRY_W'(0) - marker;
      return neg[PASSAGE_W-1:0];
   endfunction

endpackage

>>> rtl/hss_entry_ram.sv
// ----------------------------------------------------------------------------
// hss_entry_ram
// Entry memory with a write port and a registered read port, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module hss_entry_ram #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12
) (
   input  logic                          clock,
   input  hss_pkg::ram_cmd_type          cmd,
   input  logic [AW-1:0]                 wr_addr,
   input  logic [AW-1:0]                 rd_addr,
   output logic [hss_pkg::ENTRY_W-1:0]   rd_data
);
   import hss_pkg::*;

   logic [ENTRY_W-1:0] mem [DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_addr] <= cmd.wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/hit_stream_store_core.sv
// ----------------------------------------------------------------------------
// hit_stream_store_core
// Compact store of search hits kept as a stream of passage markers and words.
// ----------------------------------------------------------------------------
// write, rewind, clear: result registered in the cycle after the request;
//   a write that starts a new passage stays busy in ST_WRITE_WORD for the word
// read next hit: ST_READ_FIRST, plus ST_READ_WORD when a marker comes first;
//   at the end of data the result comes from idle; memory reads are registered
// read next passage: ST_SCAN up to the marker, then ST_READ_WORD; one at a time
// reset clears counters, marker and handshake; the store needs no clearing
// ----------------------------------------------------------------------------
module hit_stream_store_core #(
   parameter int STORE_DEPTH = 4096
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  hss_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output hss_pkg::rsp_type rsp_data
);
   import hss_pkg::*;

   localparam int AW = $clog2(STORE_DEPTH);
   localparam int CW = $clog2(STORE_DEPTH + 1);
   localparam logic [CW-1:0] FULL_LIMIT = CW'(STORE_DEPTH - 2);

   state_type            state_ff, state_in;
   logic [CW-1:0]        fill_ff, fill_in;
   logic [CW-1:0]        rpos_ff, rpos_in;
   logic [ENTRY_W-1:0]   last_ff, last_in;
   logic                 known_ff, known_in;
   logic [TOTAL_W-1:0]   total_ff, total_in;
   logic [WORD_W-1:0]    word_ff, word_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   ram_cmd_type          ram_cmd;
   logic [ENTRY_W-1:0]   rd_data;
   logic                 req_fire;
   logic                 rsp_load;
   rsp_type              rsp_new;

   // shared decisions
   logic                 reject;
   logic                 need_marker;
   logic [ENTRY_W-1:0]   new_marker;
   logic                 more_data;
   logic                 data_marker;

   assign req_ready   = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire    = req_valid && req_ready;
   assign new_marker  = marker_of(req_data.passage);
   assign reject      = (req_data.word == '0) || (fill_ff > FULL_LIMIT);
   assign need_marker = !known_ff || (last_ff != new_marker);
   assign more_data   = rpos_ff < fill_ff;
   assign data_marker = is_marker(rd_data);

   // entry memory
   hss_entry_ram #(
      .DEPTH (STORE_DEPTH),
      .AW    (AW)
   ) u_entry_ram (
      .clock   (clock),
      .cmd     (ram_cmd),
      .wr_addr (fill_ff[AW-1:0]),
      .rd_addr (rpos_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_data.op)
                  OP_WRITE: begin
                     if (!reject && need_marker) begin
                        state_in = ST_WRITE_WORD;
                     end
                  end
                  OP_READ_NEXT: begin
                     if (more_data) begin
                        state_in = ST_READ_FIRST;
                     end
                  end
                  OP_READ_PASSAGE: begin
                     if (more_data) begin
                        state_in = ST_SCAN;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_WRITE_WORD: state_in = ST_IDLE;
         ST_READ_FIRST: begin
            if (data_marker && more_data) begin
               state_in = ST_READ_WORD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (!more_data) begin
               state_in = ST_IDLE;
            end else if (data_marker) begin
               state_in = ST_READ_WORD;
            end
         end
         ST_READ_WORD: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath, memory commands and result
   always_comb begin
      fill_in         = fill_ff;
      rpos_in         = rpos_ff;
      last_in         = last_ff;
      known_in        = known_ff;
      total_in        = total_ff;
      word_in         = word_ff;
      ram_cmd         = '0;
      rsp_load        = 1'b0;
      rsp_new         = '0;
      rsp_new.total_hits = total_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_data.op)
                  OP_WRITE: begin
                     rsp_load = 1'b1;
                     if (reject) begin
                        rsp_new.rejected = 1'b1;
                     end else begin
                        ram_cmd.wr_en = 1'b1;
                        fill_in       = fill_ff + CW'(1);
                        total_in      = total_ff + TOTAL_W'(1);
                        rsp_new.total_hits = total_ff + TOTAL_W'(1);
                        if (need_marker) begin
                           ram_cmd.wr_data = new_marker;
                           last_in         = new_marker;
                           known_in        = 1'b1;
                           word_in         = req_data.word;
                        end else begin
                           ram_cmd.wr_data = {1'b0, req_data.word};
                        end
                     end
                  end
                  OP_READ_NEXT, OP_READ_PASSAGE: begin
                     if (more_data) begin
                        ram_cmd.rd_en = 1'b1;
                        rpos_in       = rpos_ff + CW'(1);
                     end else begin
                        rsp_load = 1'b1;
                     end
                  end
                  OP_REWIND: begin
                     rpos_in  = '0;
                     known_in = 1'b0;
                     rsp_load = 1'b1;
                  end
                  OP_CLEAR: begin
                     fill_in  = '0;
                     rpos_in  = '0;
                     last_in  = '0;
                     known_in = 1'b0;
                     total_in = '0;
                     rsp_load = 1'b1;
                     rsp_new.total_hits = '0;
                  end
                  default: rsp_load = 1'b1;
               endcase
            end
         end

         // word following a freshly written marker
         ST_WRITE_WORD: begin
            ram_cmd.wr_en   = 1'b1;
            ram_cmd.wr_data = {1'b0, word_ff};
            fill_in         = fill_ff + CW'(1);
         end

         // first entry of a read or one entry of a passage scan
         ST_READ_FIRST, ST_SCAN: begin
            if (data_marker) begin
               last_in  = rd_data;
               known_in = 1'b1;
               if (more_data) begin
                  ram_cmd.rd_en = 1'b1;
                  rpos_in       = rpos_ff + CW'(1);
               end else begin
                  rsp_load = 1'b1;
               end
            end else if (state_ff == ST_READ_FIRST) begin
               rsp_load            = 1'b1;
               rsp_new.found       = 1'b1;
               rsp_new.hit_word    = rd_data[WORD_W-1:0];
               rsp_new.hit_passage = known_ff ? passage_of(last_ff) : '0;
            end else if (more_data) begin
               ram_cmd.rd_en = 1'b1;
               rpos_in       = rpos_ff + CW'(1);
            end else begin
               rsp_load = 1'b1;
            end
         end

         // word after a marker
         ST_READ_WORD: begin
            rsp_load            = 1'b1;
            rsp_new.found       = 1'b1;
            rsp_new.hit_word    = rd_data[WORD_W-1:0];
            rsp_new.hit_passage = passage_of(last_ff);
         end

         default: ;
      endcase
   end

   // result register
   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (rsp_load) begin
         rsp_data_in  = rsp_new;
         rsp_valid_in = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         rpos_ff      <= '0;
         last_ff      <= '0;
         known_ff     <= 1'b0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rpos_ff      <= rpos_in;
         last_ff      <= last_in;
         known_ff     <= known_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      word_ff     <= word_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> rtl/hss_checker.sv
// ----------------------------------------------------------------------------
// hss_checker
// Port-level checks of the hit stream store, bound to hit_stream_store_core.
// ----------------------------------------------------------------------------
module hss_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input hss_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input hss_pkg::rsp_type rsp_data
);
   import hss_pkg::*;

   // a waiting result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // a result never reports both a hit and a rejected write
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.found && rsp_data.rejected))
      else $error("found and rejected together");

   // a result without a hit carries zero hit fields
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |-> rsp_data.hit_passage == '0 && rsp_data.hit_word == '0)
      else $error("hit fields set without a hit");

   // clear answers next cycle with an empty total
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.op == OP_CLEAR
      |=> rsp_valid && rsp_data.total_hits == '0 && !rsp_data.found)
      else $error("clear result wrong");

   // rewind answers next cycle with no hit and no rejection
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.op == OP_REWIND
      |=> rsp_valid && !rsp_data.found && !rsp_data.rejected)
      else $error("rewind result wrong");

endmodule

bind hit_stream_store_core hss_checker u_hss_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
